### rtl/core/stl_pkg.sv
// Shared types and constants of the string token lexer.
package stl_pkg;

   localparam int POS_BITS_DEFAULT = 16;
   localparam int OUT_POS_BITS     = 16;
   localparam int MAX_RESULTS      = 3;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_STR_END = 2'd1,
      KIND_EOI = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_BAD_ESCAPE = 3'd1,
      ERR_BAD_HEX = 3'd2,
      ERR_BAD_UNICODE = 3'd3,
      ERR_UNEXPECTED = 3'd4,
      ERR_UNTERMINATED = 3'd5
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      err_type     err;
      logic [15:0] line_no;
      logic [15:0] col_no;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] res;
   } step_out_type;

endpackage

### rtl/core/stl_if.sv
// Handshake channels for source words and result words.
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  out_byte;
   logic [2:0]  error_code;
   logic [15:0] line_no;
   logic [15:0] col_no;
   logic        last;
   modport source (output valid, output out_kind, output out_byte, output error_code,
                   output line_no, output col_no, output last, input ready);
   modport sink (input valid, input out_kind, input out_byte, input error_code,
                 input line_no, input col_no, input last, output ready);
endinterface

### rtl/core/stl_lex_core.sv
// Lexer state and the combinational decode of one source word.
module stl_lex_core import stl_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   in_byte,
   output step_out_type step_out
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_STRING = 3'd2,
      MODE_ESCAPE = 3'd3,
      MODE_HEX = 3'd4
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [1:0]          hex_count_ff, hex_count_in;
   logic [15:0]         code_acc_ff, code_acc_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] col_ff, col_in;
   logic                halted_ff, halted_in;

   logic [POS_BITS-1:0] cur_line, cur_col;
   logic [15:0]         cur_line16, cur_col16;
   logic [15:0]         acc_next;
   logic [3:0]          hex_digit;
   logic                hex_ok;
   logic [1:0]          n;
   kind_type            kinds [MAX_RESULTS];
   logic [7:0]          bytes [MAX_RESULTS];
   err_type             errs [MAX_RESULTS];

   // clip position to the 16-bit report width
   generate
      if (POS_BITS > OUT_POS_BITS) begin : g_clip
         assign cur_line16 = (|cur_line[POS_BITS-1:OUT_POS_BITS]) ? 16'hFFFF
                                                                   : cur_line[15:0];
         assign cur_col16  = (|cur_col[POS_BITS-1:OUT_POS_BITS]) ? 16'hFFFF
                                                                 : cur_col[15:0];
      end else begin : g_ext
         assign cur_line16 = OUT_POS_BITS'(cur_line);
         assign cur_col16  = OUT_POS_BITS'(cur_col);
      end
   endgenerate

   always_comb begin
      hex_ok    = 1'b1;
      hex_digit = 4'd0;
      case (in_byte) inside
         ["0":"9"]: hex_digit = 4'(in_byte - 8'h30);
         ["A":"F"]: hex_digit = 4'(in_byte - 8'h37);
         ["a":"f"]: hex_digit = 4'(in_byte - 8'h57);
         default:   hex_ok = 1'b0;
      endcase
   end

   assign acc_next = {code_acc_ff[11:0], hex_digit};

   always_comb begin
      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      code_acc_in  = code_acc_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      halted_in    = halted_ff;
      cur_line     = line_ff;
      cur_col      = col_ff;
      n            = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         kinds[i] = KIND_BYTE;
         bytes[i] = 8'h00;
         errs[i]  = ERR_NONE;
      end

      if (!halted_ff && in_byte != CHAR_CR) begin
         // position of this word
         if (in_byte == CHAR_LF) begin
            line_in  = (line_ff == '1) ? line_ff : line_ff + 1'b1;
            cur_line = line_in;
            cur_col  = '0;
            col_in   = POS_BITS'(1);
         end else if (in_byte != CHAR_NUL) begin
            col_in = (col_ff == '1) ? col_ff : col_ff + 1'b1;
         end

         case (mode_ff)
            MODE_COMMENT: begin
               if (in_byte == CHAR_NUL) begin
                  mode_in  = MODE_IDLE;
                  n        = 2'd1;
                  kinds[0] = KIND_EOI;
               end else if (in_byte == CHAR_LF) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_STRING: begin
               if (in_byte == CHAR_NUL) begin
                  n        = 2'd1;
                  kinds[0] = KIND_ERROR;
                  errs[0]  = ERR_UNTERMINATED;
               end else if (in_byte == CHAR_QUOTE) begin
                  mode_in  = MODE_IDLE;
                  n        = 2'd1;
                  kinds[0] = KIND_STR_END;
               end else if (in_byte == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  n        = 2'd1;
                  bytes[0] = in_byte;
               end
            end
            MODE_ESCAPE: begin
               mode_in = MODE_STRING;
               n       = 2'd1;
               case (in_byte)
                  CHAR_NUL: begin
                     kinds[0] = KIND_ERROR;
                     errs[0]  = ERR_UNTERMINATED;
                  end
                  CHAR_QUOTE:     bytes[0] = CHAR_QUOTE;
                  "b":            bytes[0] = 8'h08;
                  "f":            bytes[0] = 8'h0C;
                  "n":            bytes[0] = 8'h0A;
                  "r":            bytes[0] = 8'h0D;
                  "t":            bytes[0] = 8'h09;
                  CHAR_BACKSLASH: bytes[0] = CHAR_BACKSLASH;
                  "u": begin
                     mode_in      = MODE_HEX;
                     hex_count_in = 2'd0;
                     code_acc_in  = 16'h0000;
                     n            = 2'd0;
                  end
                  default: begin
                     kinds[0] = KIND_ERROR;
                     errs[0]  = ERR_BAD_ESCAPE;
                  end
               endcase
            end
            MODE_HEX: begin
               if (in_byte == CHAR_NUL) begin
                  n        = 2'd1;
                  kinds[0] = KIND_ERROR;
                  errs[0]  = ERR_UNTERMINATED;
               end else if (!hex_ok) begin
                  n        = 2'd1;
                  kinds[0] = KIND_ERROR;
                  errs[0]  = ERR_BAD_HEX;
               end else if (hex_count_ff != 2'd3) begin
                  code_acc_in  = acc_next;
                  hex_count_in = hex_count_ff + 2'd1;
               end else begin
                  // fourth digit: encode the code point as UTF-8
                  hex_count_in = 2'd0;
                  code_acc_in  = 16'h0000;
                  mode_in      = MODE_STRING;
                  if (acc_next >= 16'hD800 && acc_next <= 16'hDFFF) begin
                     n        = 2'd1;
                     kinds[0] = KIND_ERROR;
                     errs[0]  = ERR_BAD_UNICODE;
                  end else if (acc_next < 16'h0080) begin
                     n        = 2'd1;
                     bytes[0] = acc_next[7:0];
                  end else if (acc_next < 16'h0800) begin
                     n        = 2'd2;
                     bytes[0] = {3'b110, acc_next[10:6]};
                     bytes[1] = {2'b10, acc_next[5:0]};
                  end else begin
                     n        = 2'd3;
                     bytes[0] = {4'b1110, acc_next[15:12]};
                     bytes[1] = {2'b10, acc_next[11:6]};
                     bytes[2] = {2'b10, acc_next[5:0]};
                  end
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               if (in_byte == CHAR_SPACE || in_byte == CHAR_TAB || in_byte == CHAR_LF) begin
                  mode_in = MODE_IDLE;
               end else if (in_byte == CHAR_HASH) begin
                  mode_in = MODE_COMMENT;
               end else if (in_byte == CHAR_NUL) begin
                  n        = 2'd1;
                  kinds[0] = KIND_EOI;
               end else if (in_byte == CHAR_QUOTE) begin
                  mode_in = MODE_STRING;
               end else begin
                  n        = 2'd1;
                  kinds[0] = KIND_ERROR;
                  errs[0]  = ERR_UNEXPECTED;
               end
            end
         endcase

         // any error halts and drops back to idle
         if (n != 2'd0 && kinds[0] == KIND_ERROR) begin
            halted_in    = 1'b1;
            mode_in      = MODE_IDLE;
            hex_count_in = 2'd0;
            code_acc_in  = 16'h0000;
         end
      end
   end

   always_comb begin
      step_out.count = n;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         step_out.res[i].kind    = kinds[i];
         step_out.res[i].data    = bytes[i];
         step_out.res[i].err     = errs[i];
         step_out.res[i].line_no = cur_line16;
         step_out.res[i].col_no  = cur_col16;
         step_out.res[i].last    = (2'(i + 1) == n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         hex_count_ff <= 2'd0;
         code_acc_ff  <= 16'h0000;
         line_ff      <= POS_BITS'(1);
         col_ff       <= POS_BITS'(1);
         halted_ff    <= 1'b0;
      end else if (step) begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         code_acc_ff  <= code_acc_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         halted_ff    <= halted_in;
      end
   end

endmodule

### rtl/core/stl_rsp_queue.sv
// Result queue: takes up to three words per cycle, hands out one.
module stl_rsp_queue import stl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  step_out_type push_data,
   output logic         room,
   output logic         head_valid,
   input  logic         head_ready,
   output result_type   head
);

   result_type q_ff [QUEUE_DEPTH];
   result_type q_in [QUEUE_DEPTH];
   logic [2:0] count_ff, count_in;
   logic [2:0] base;
   logic [2:0] slot;
   logic [2:0] push_n;
   logic       pop;

   // room for a full burst of results on top of one waiting word
   assign room       = (count_ff <= 3'd1);
   assign head_valid = (count_ff != 3'd0);
   assign head       = q_ff[0];

   always_comb begin
      pop    = head_valid && head_ready;
      push_n = push ? {1'b0, push_data.count} : 3'd0;
      base   = pop ? count_ff - 3'd1 : count_ff;
      // advance the line on a pop
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         q_in[i] = pop ? q_ff[i+1] : q_ff[i];
      end
      q_in[QUEUE_DEPTH-1] = q_ff[QUEUE_DEPTH-1];
      // append new words behind the ones still waiting
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot = 3'(i) - base;
         if (3'(i) >= base && slot < push_n) begin
            q_in[i] = push_data.res[slot[1:0]];
         end
      end
      count_in = base + push_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

### rtl/core/string_token_lexer_top.sv
// Top level of the string token lexer: source words in, token words out.
//
// Channels: req carries one source byte per word (zero marks end of
// source); rsp carries result words of kind string byte, string end,
// end of input or error, each with the line and column of the byte that
// caused it and a last flag on the final word of that byte.
// Output: result words are registered in the queue when their byte is
// taken. Throughput: one byte per cycle while each byte yields at most
// one word and rsp is ready; a closing \u digit yielding two or three
// UTF-8 bytes holds req low while the queue drains. The rate is set by the
// four-entry result queue, which takes a byte while at most one word waits.
// Reset: the lexer returns to idle at line 1, column 1 with no error,
// and the result queue is emptied.
// Stall: when rsp is held off, waiting words stay in the queue and req
// drops once the queue could not take another full burst.
// After an error, every byte is taken and dropped until reset.
module string_token_lexer_top import stl_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   stl_req_if.sink     req_if,
   stl_rsp_if.source   rsp_if
);

   step_out_type step_out;
   result_type   head;
   logic         room;
   logic         take;

   assign req_if.ready = room;
   assign take         = req_if.valid && room;

   // decode the byte and advance lexer state on acceptance
   stl_lex_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (take),
      .in_byte  (req_if.in_byte),
      .step_out (step_out)
   );

   // hold results until the receiver takes them
   stl_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_data  (step_out),
      .room       (room),
      .head_valid (rsp_if.valid),
      .head_ready (rsp_if.ready),
      .head       (head)
   );

   assign rsp_if.out_kind   = head.kind;
   assign rsp_if.out_byte   = head.data;
   assign rsp_if.error_code = head.err;
   assign rsp_if.line_no    = head.line_no;
   assign rsp_if.col_no     = head.col_no;
   assign rsp_if.last       = head.last;

endmodule
